// ===== hdl/atsc_pkg.sv =====
// Package holding the shared types, widths and constant tables of the tilt block.
package atsc_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int MAG_W            = 17;
    localparam int SQ_W             = 31;
    localparam int SUM_W            = 32;
    localparam int RAD_W            = 48;
    localparam int ROOT_W           = 24;
    localparam int REM_W            = 26;
    localparam int CX_W             = 29;
    localparam int CZ_W             = 17;
    localparam int DEG_W            = 7;
    localparam int Q_DEPTH          = 2;

    // 90 degrees in 1/256 degree.
    localparam logic [15:0] ANGLE_MAX = 16'd23040;
    localparam logic [DEG_W-1:0] DEG_RIGHT = 7'd90;
    localparam logic [3:0] CLASS_NO_UPDATE = 4'd9;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic signed [7:0] tilt_x_deg;
        logic signed [7:0] tilt_y_deg;
        logic [3:0]        speed_class;
        logic [13:0]       period_reload;
        logic              reload_update;
    } result_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic             neg_x;
        logic             neg_y;
        logic             zero_x;
        logic             zero_y;
    } side_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root_x;
        logic [ROOT_W-1:0] root_y;
        side_t             side;
    } qword_t;

    // atan(2^-i) in 1/256 degree, rounded to nearest.
    function automatic logic [13:0] atan_val(input int i);
        logic [13:0] r;
        case (i)
            0:       r = 14'd11520;
            1:       r = 14'd6801;
            2:       r = 14'd3593;
            3:       r = 14'd1824;
            4:       r = 14'd916;
            5:       r = 14'd458;
            6:       r = 14'd229;
            7:       r = 14'd115;
            8:       r = 14'd57;
            9:       r = 14'd29;
            10:      r = 14'd14;
            11:      r = 14'd7;
            12:      r = 14'd4;
            13:      r = 14'd2;
            14:      r = 14'd1;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

    function automatic logic [13:0] reload_val(input logic [3:0] cls);
        logic [13:0] r;
        case (cls)
            4'd0:    r = 14'd9499;
            4'd1:    r = 14'd6999;
            4'd2:    r = 14'd5999;
            4'd3:    r = 14'd4999;
            4'd4:    r = 14'd3999;
            4'd5:    r = 14'd2999;
            4'd6:    r = 14'd1999;
            4'd7:    r = 14'd999;
            4'd8:    r = 14'd499;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/atsc_front.sv =====
// Front pipeline: magnitudes, squares and a bit-per-stage square root of each denominator.
module atsc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  atsc_pkg::sample_t  sample,
    output logic               f_valid,
    input  logic               f_ready,
    output atsc_pkg::qword_t   f_word
);

    localparam int NB    = atsc_pkg::ROOT_W;
    localparam int DEPTH = 3 + NB;

    logic [DEPTH-1:0] vld_reg;
    logic             adv;

    logic [atsc_pkg::MAG_W-1:0] ext_x, ext_y, ext_z;
    logic [atsc_pkg::MAG_W-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic                       neg_x_reg, neg_y_reg;
    logic [33:0]                px, py, pz;
    logic [atsc_pkg::SQ_W-1:0]  sq_x_reg, sq_y_reg, sq_z_reg;
    atsc_pkg::side_t            side1_reg;
    atsc_pkg::side_t            side0;
    logic [atsc_pkg::SUM_W-1:0] sum_x, sum_y;

    logic [atsc_pkg::RAD_W-1:0]  rad_reg  [2][NB+1];
    logic [atsc_pkg::REM_W-1:0]  rem_reg  [2][NB+1];
    logic [atsc_pkg::ROOT_W-1:0] root_reg [2][NB+1];
    atsc_pkg::side_t             side_reg [NB+1];

    assign adv          = !vld_reg[DEPTH-1] || f_ready;
    assign sample_ready = adv;
    assign f_valid      = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], sample_valid};
        end
    end

    assign ext_x = {sample.accel_x[15], sample.accel_x};
    assign ext_y = {sample.accel_y[15], sample.accel_y};
    assign ext_z = {sample.accel_z[15], sample.accel_z};

    assign px = mag_x_reg * mag_x_reg;
    assign py = mag_y_reg * mag_y_reg;
    assign pz = mag_z_reg * mag_z_reg;

    assign sum_x = {1'b0, sq_y_reg} + {1'b0, sq_z_reg};
    assign sum_y = {1'b0, sq_x_reg} + {1'b0, sq_z_reg};

    // Sideband of the radicand stage, with the zero-denominator flags filled in.
    always_comb
    begin
        side0        = side1_reg;
        side0.zero_x = (sum_x == '0);
        side0.zero_y = (sum_y == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_x_reg <= ext_x[16] ? (~ext_x + 17'd1) : ext_x;
            mag_y_reg <= ext_y[16] ? (~ext_y + 17'd1) : ext_y;
            mag_z_reg <= ext_z[16] ? (~ext_z + 17'd1) : ext_z;
            neg_x_reg <= ext_x[16];
            neg_y_reg <= ext_y[16];

            sq_x_reg         <= px[atsc_pkg::SQ_W-1:0];
            sq_y_reg         <= py[atsc_pkg::SQ_W-1:0];
            sq_z_reg         <= pz[atsc_pkg::SQ_W-1:0];
            side1_reg.mag_x  <= mag_x_reg;
            side1_reg.mag_y  <= mag_y_reg;
            side1_reg.neg_x  <= neg_x_reg;
            side1_reg.neg_y  <= neg_y_reg;
            side1_reg.zero_x <= 1'b0;
            side1_reg.zero_y <= 1'b0;

            rad_reg[0][0]  <= {sum_x, 16'd0};
            rad_reg[1][0]  <= {sum_y, 16'd0};
            rem_reg[0][0]  <= '0;
            rem_reg[1][0]  <= '0;
            root_reg[0][0] <= '0;
            root_reg[1][0] <= '0;
            side_reg[0]    <= side0;
        end
    end

    // One result bit per stage: bring down the next pair of radicand bits and
    // subtract the trial divisor when it fits.
    for (genvar k = 0; k < NB; k++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end

        for (genvar a = 0; a < 2; a++)
        begin : g_axis
            logic [27:0] tmp;
            logic [27:0] trial;
            logic        ge;

            assign tmp   = {rem_reg[a][k], rad_reg[a][k][atsc_pkg::RAD_W-1 -: 2]};
            assign trial = {2'b00, root_reg[a][k], 2'b01};
            assign ge    = (tmp >= trial);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rad_reg[a][k+1]  <= {rad_reg[a][k][atsc_pkg::RAD_W-3:0], 2'b00};
                    rem_reg[a][k+1]  <= ge ? 26'(tmp - trial) : tmp[atsc_pkg::REM_W-1:0];
                    root_reg[a][k+1] <= {root_reg[a][k][atsc_pkg::ROOT_W-2:0], ge};
                end
            end
        end
    end

    assign f_word.root_x = root_reg[0][NB];
    assign f_word.root_y = root_reg[1][NB];
    assign f_word.side   = side_reg[NB];

endmodule

// ===== hdl/atsc_queue.sv =====
// Two-word queue between the front and back pipelines.
module atsc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  atsc_pkg::qword_t  push_word,
    output logic              pop_valid,
    input  logic              pop_ready,
    output atsc_pkg::qword_t  pop_word
);

    localparam int PW = $clog2(atsc_pkg::Q_DEPTH);

    atsc_pkg::qword_t mem_reg [atsc_pkg::Q_DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [PW:0]      count_reg;
    logic             push, pop;

    assign push_ready = (count_reg != (PW+1)'(atsc_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_word;
        end
    end

endmodule

// ===== hdl/atsc_back.sv =====
// Back pipeline: one CORDIC stage per step for each axis, degree conversion and speed class.
module atsc_back #(
    parameter int STEPS = atsc_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  atsc_pkg::qword_t  q_word,
    output logic              result_valid,
    input  logic              result_ready,
    output atsc_pkg::result_t result
);

    localparam int XW    = atsc_pkg::CX_W;
    localparam int ZW    = atsc_pkg::CZ_W;
    localparam int DEPTH = STEPS + 3;

    logic [DEPTH-1:0] vld_reg;
    logic             adv;

    logic [XW-1:0]   cx_reg [2][STEPS+1];
    logic [XW-1:0]   cy_reg [2][STEPS+1];
    logic [ZW-1:0]   cz_reg [2][STEPS+1];
    atsc_pkg::side_t sd_reg [STEPS+1];

    logic [atsc_pkg::DEG_W-1:0] deg_x_reg, deg_y_reg;
    logic signed [7:0]          tilt_x_reg, tilt_y_reg;
    logic [atsc_pkg::DEG_W-1:0] deg_c [2];
    logic signed [7:0]          tilt_c [2];
    logic [atsc_pkg::DEG_W-1:0] deg_max;
    logic [14:0]                cls_prod;
    logic [3:0]                 cls;

    // Arithmetic shift right that truncates toward zero.
    function automatic logic [XW-1:0] shr_tz(input logic [XW-1:0] v, input int k);
        logic [XW-1:0] m;
        m = v[XW-1] ? (~v + 1'b1) : v;
        m = m >> k;
        return v[XW-1] ? (~m + 1'b1) : m;
    endfunction

    assign adv          = !vld_reg[DEPTH-1] || result_ready;
    assign q_ready      = adv;
    assign result_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0][0] <= {5'd0, q_word.root_x};
            cx_reg[1][0] <= {5'd0, q_word.root_y};
            cy_reg[0][0] <= {4'd0, q_word.side.mag_x, 8'd0};
            cy_reg[1][0] <= {4'd0, q_word.side.mag_y, 8'd0};
            cz_reg[0][0] <= '0;
            cz_reg[1][0] <= '0;
            sd_reg[0]    <= q_word.side;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sd_reg[i+1] <= sd_reg[i];
            end
        end

        for (genvar a = 0; a < 2; a++)
        begin : g_axis
            logic [XW-1:0] dx, dy;
            logic [ZW-1:0] ang;

            assign dx  = shr_tz(cy_reg[a][i], i);
            assign dy  = shr_tz(cx_reg[a][i], i);
            assign ang = ZW'(atsc_pkg::atan_val(i));

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!cy_reg[a][i][XW-1])
                    begin
                        cx_reg[a][i+1] <= cx_reg[a][i] + dx;
                        cy_reg[a][i+1] <= cy_reg[a][i] - dy;
                        cz_reg[a][i+1] <= cz_reg[a][i] + ang;
                    end
                    else
                    begin
                        cx_reg[a][i+1] <= cx_reg[a][i] - dx;
                        cy_reg[a][i+1] <= cy_reg[a][i] + dy;
                        cz_reg[a][i+1] <= cz_reg[a][i] - ang;
                    end
                end
            end
        end
    end

    // Clamp to 0..90 degrees, take whole degrees, and handle a zero denominator.
    for (genvar a = 0; a < 2; a++)
    begin : g_deg
        logic [ZW-1:0] z;
        logic [15:0]   zc;
        logic          zero, nz, neg;

        assign z    = cz_reg[a][STEPS];
        assign zero = (a == 0) ? sd_reg[STEPS].zero_x : sd_reg[STEPS].zero_y;
        assign nz   = (a == 0) ? (sd_reg[STEPS].mag_x != '0) : (sd_reg[STEPS].mag_y != '0);
        assign neg  = (a == 0) ? sd_reg[STEPS].neg_x : sd_reg[STEPS].neg_y;

        always_comb
        begin
            if (z[ZW-1])
            begin
                zc = '0;
            end
            else if (z[15:0] > atsc_pkg::ANGLE_MAX)
            begin
                zc = atsc_pkg::ANGLE_MAX;
            end
            else
            begin
                zc = z[15:0];
            end

            if (zero)
            begin
                deg_c[a] = nz ? atsc_pkg::DEG_RIGHT : '0;
            end
            else
            begin
                deg_c[a] = zc[14:8];
            end
            tilt_c[a] = neg ? -$signed({1'b0, deg_c[a]}) : $signed({1'b0, deg_c[a]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg_x_reg  <= deg_c[0];
            deg_y_reg  <= deg_c[1];
            tilt_x_reg <= tilt_c[0];
            tilt_y_reg <= tilt_c[1];
        end
    end

    // Division by ten through the reciprocal 205/2048, exact for 0..90.
    assign deg_max  = (deg_x_reg >= deg_y_reg) ? deg_x_reg : deg_y_reg;
    assign cls_prod = deg_max * 8'd205;
    assign cls      = cls_prod[14:11];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result.tilt_x_deg    <= tilt_x_reg;
            result.tilt_y_deg    <= tilt_y_reg;
            result.speed_class   <= cls;
            result.period_reload <= atsc_pkg::reload_val(cls);
            result.reload_update <= (cls != atsc_pkg::CLASS_NO_UPDATE);
        end
    end

endmodule

// ===== hdl/accel_tilt_angle_speed_class_core.sv =====
// Top level of the accelerometer tilt angle and speed class block.
//
//  channel  | handshake                   | word
//  ---------+-----------------------------+-------------------------------------------
//  sample   | sample_valid / sample_ready | accel_x, accel_y, accel_z
//  result   | result_valid / result_ready | tilt_x_deg, tilt_y_deg, speed_class,
//           |                             | period_reload, reload_update
//
// One sample word is taken every clock while sample_ready is high; one result word
// is given per sample. The front has three setup stages and one square-root bit per
// stage, and the back has an input stage, one CORDIC stage per step, a degree stage
// and a result stage. Reset clears only the valid bits and the queue pointers and
// count; no clearing pass is needed. The front and back stall independently; the
// two-word queue absorbs a result stall until full, then the sample side stalls too.
module accel_tilt_angle_speed_class_core #(
    parameter int CORDIC_STEPS = atsc_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  atsc_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output atsc_pkg::result_t result
);

    // Words leaving the front: the square roots of both denominators plus the per-axis sideband.
    logic             f_valid, f_ready;
    atsc_pkg::qword_t f_word;

    // Words entering the back from the queue.
    logic             q_valid, q_ready;
    atsc_pkg::qword_t q_word;

    atsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .f_valid      (f_valid),
        .f_ready      (f_ready),
        .f_word       (f_word)
    );

    atsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_word  (f_word),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_word   (q_word)
    );

    // The back runs the CORDIC for both tilt axes side by side.
    atsc_back #(
        .STEPS (CORDIC_STEPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_word       (q_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== hdl/atsc_checker.sv =====
// Port-level checks of the tilt block, bound to its top level.
module atsc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_ready,
    input logic              result_valid,
    input logic              result_ready,
    input atsc_pkg::result_t result
);

    logic [7:0] abs_x, abs_y, abs_max;
    logic [7:0] cls10;

    assign abs_x   = result.tilt_x_deg[7] ? 8'(-result.tilt_x_deg) : result.tilt_x_deg;
    assign abs_y   = result.tilt_y_deg[7] ? 8'(-result.tilt_y_deg) : result.tilt_y_deg;
    assign abs_max = (abs_x >= abs_y) ? abs_x : abs_y;
    assign cls10   = {4'd0, result.speed_class} * 8'd10;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> abs_x <= 8'd90 && abs_y <= 8'd90)
        else $error("tilt out of range");

    a_class: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> cls10 <= abs_max && abs_max < cls10 + 8'd10)
        else $error("speed class does not match tilt");

    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result.reload_update == (result.speed_class != atsc_pkg::CLASS_NO_UPDATE))
            && (result.reload_update || result.period_reload == 14'd0))
        else $error("reload flag or value wrong");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(result_valid) && (!sample_valid || !$isunknown(sample_ready)))
        else $error("handshake output unknown");

endmodule

bind accel_tilt_angle_speed_class_core atsc_checker u_atsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ===== verif/accel_tilt_angle_speed_class_core_test.sv =====
// Testbench for the accelerometer tilt angle and speed class block.
`timescale 1ns / 100ps

module accel_tilt_angle_speed_class_core_test;

    localparam int STEPS = atsc_pkg::CORDIC_STEPS_DEF;
    // Sum of the front, queue and back pipeline depths, plus a margin.
    localparam int DRAIN_CYCLES = 27 + 1 + STEPS + 3 + 20;
    localparam int RANDOM_WORDS = 1350;

    logic              clk;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_ready;
    atsc_pkg::sample_t sample;
    logic              result_valid;
    logic              result_ready;
    atsc_pkg::result_t result;

    int  error_count = 0;
    bit  stall_enable = 1'b1;
    int  directed_count = 0;

    // Prints one line per mismatch and keeps the running count.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Predicts the results of accepted samples and checks the returned words in order.
    class tilt_scoreboard;
        atsc_pkg::result_t pending_results[$];
        int                checked_count = 0;

        // Truncating right shift on the magnitude of a signed value.
        function automatic longint shift_toward_zero(longint v, int k);
            if (v >= 0)
                return v >>> k;
            return -((-v) >>> k);
        endfunction

        function automatic longint int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= root + bitv)
                begin
                    v -= root + bitv;
                    root = (root >> 1) + bitv;
                end
                else
                    root >>= 1;
                bitv >>= 2;
            end
            return longint'(root);
        endfunction

        function automatic int atan_step(int i);
            int t[15] = '{11520, 6801, 3593, 1824, 916, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1};
            return (i < 15) ? t[i] : 0;
        endfunction

        // Signed tilt in whole degrees of axis a against axes b and c.
        function automatic int axis_tilt(int a, int b, int c);
            longint unsigned ma, mb, mc, s;
            longint cx, cy, ang, dx, dy;
            int deg;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            mc = (c < 0) ? -c : c;
            s = mb * mb + mc * mc;
            if (s == 0)
                deg = (ma == 0) ? 0 : 90;
            else
            begin
                cx = int_sqrt(s << 16);
                cy = longint'(ma << 8);
                ang = 0;
                for (int i = 0; i < STEPS && i < 24; i++)
                begin
                    dx = shift_toward_zero(cy, i);
                    dy = shift_toward_zero(cx, i);
                    if (cy >= 0)
                    begin
                        cx += dx;
                        cy -= dy;
                        ang += atan_step(i);
                    end
                    else
                    begin
                        cx -= dx;
                        cy += dy;
                        ang -= atan_step(i);
                    end
                end
                if (ang < 0)
                    ang = 0;
                if (ang > 23040)
                    ang = 23040;
                deg = int'(ang >>> 8);
            end
            return (a < 0) ? -deg : deg;
        endfunction

        function void note_sample(atsc_pkg::sample_t s);
            int tx, ty, mx, my, cls;
            int reloads[9] = '{9499, 6999, 5999, 4999, 3999, 2999, 1999, 999, 499};
            atsc_pkg::result_t r;
            tx = axis_tilt(s.accel_x, s.accel_y, s.accel_z);
            ty = axis_tilt(s.accel_y, s.accel_x, s.accel_z);
            mx = (tx < 0) ? -tx : tx;
            my = (ty < 0) ? -ty : ty;
            cls = ((mx >= my) ? mx : my) / 10;
            r.tilt_x_deg    = tx[7:0];
            r.tilt_y_deg    = ty[7:0];
            r.speed_class   = cls[3:0];
            r.period_reload = (cls < 9) ? reloads[cls][13:0] : 14'd0;
            r.reload_update = (cls < 9);
            pending_results.push_back(r);
        endfunction

        task check_result(atsc_pkg::result_t got);
            atsc_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result word", 1, 0);
                return;
            end
            want = pending_results.pop_front();
            checked_count++;
            if (got.tilt_x_deg !== want.tilt_x_deg)
                report_mismatch("tilt_x_deg", got.tilt_x_deg, want.tilt_x_deg);
            if (got.tilt_y_deg !== want.tilt_y_deg)
                report_mismatch("tilt_y_deg", got.tilt_y_deg, want.tilt_y_deg);
            if (got.speed_class !== want.speed_class)
                report_mismatch("speed_class", got.speed_class, want.speed_class);
            if (got.period_reload !== want.period_reload)
                report_mismatch("period_reload", got.period_reload, want.period_reload);
            if (got.reload_update !== want.reload_update)
                report_mismatch("reload_update", got.reload_update, want.reload_update);
        endtask
    endclass

    tilt_scoreboard board = new();

    accel_tilt_angle_speed_class_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 20 ns clock.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sends one sample word: an optional random idle burst first, then valid is held
    // until the handshake. Valid is not dropped between back-to-back words.
    task automatic send_sample(input atsc_pkg::sample_t s);
        if (stall_enable && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        board.note_sample(s);
    endtask

    // Draws one axis value, leaning on the extremes and on small values so the
    // near-zero and right-angle regions get plenty of hits.
    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($signed($urandom_range(0, 8)) - 4);
            4:       return 16'($signed($urandom_range(0, 2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    // Result side: random stall bursts while stalling is on, checked at each handshake.
    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_enable && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            if (result_valid && result_ready)
                board.check_result(result);
        end
    end

    // Main stimulus: reset, a directed set of corner samples, then random traffic.
    initial
    begin
        atsc_pkg::sample_t s;
        int drain_wait;
        sample_valid = 1'b0;
        sample       = '0;
        rst_n        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed part: all-zero sample, zero denominators, the most negative value
        // on each axis, exact right angles and a class-9 tilt.
        begin
            logic [15:0] dir[18][3] = '{
                '{16'h0000, 16'h0000, 16'h0000},
                '{16'h0001, 16'h0000, 16'h0000},
                '{16'hFFFF, 16'h0000, 16'h0000},
                '{16'h0000, 16'h8000, 16'h0000},
                '{16'h8000, 16'h8000, 16'h8000},
                '{16'h7FFF, 16'h7FFF, 16'h7FFF},
                '{16'h8000, 16'h0000, 16'h0001},
                '{16'h7FFF, 16'h0000, 16'h0000},
                '{16'h0000, 16'h0000, 16'h7FFF},
                '{16'h0000, 16'h0000, 16'h8000},
                '{16'h7FFF, 16'h0001, 16'h0000},
                '{16'h0001, 16'h7FFF, 16'h8000},
                '{16'd4000, 16'd0,    16'd16000},
                '{16'd8000, 16'd8000, 16'd8000},
                '{16'd16000, 16'hC180, 16'd1000},
                '{16'h5555, 16'hAAAA, 16'h5555},
                '{16'hAAAA, 16'h5555, 16'hAAAA},
                '{16'd100,  16'd200,  16'd16384}};
            foreach (dir[i])
            begin
                s.accel_x = dir[i][0];
                s.accel_y = dir[i][1];
                s.accel_z = dir[i][2];
                send_sample(s);
                directed_count++;
            end
        end

        // Random part, with a full pause midway until the results drain.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 2)
            begin
                sample_valid <= 1'b0;
                @(posedge clk);
                while (board.pending_results.size() != 0)
                    @(posedge clk);
            end
            if (n == RANDOM_WORDS - 200)
                stall_enable = 1'b0;
            s.accel_x = pick_axis();
            s.accel_y = pick_axis();
            s.accel_z = pick_axis();
            send_sample(s);
        end
        sample_valid <= 1'b0;

        // Wait for every expected result, then a latency's worth of extra cycles.
        drain_wait = 0;
        while (board.pending_results.size() != 0 && drain_wait < 100000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.pending_results.size() != 0)
            report_mismatch("results never returned", 0, board.pending_results.size());

        $display("Covered %0d directed corner samples and %0d random samples,",
                 directed_count, RANDOM_WORDS);
        $display("with %0d result words checked under random stalls.", board.checked_count);
        if (error_count == 0)
            $display("[accel_tilt_angle_speed_class_core] OK");
        else
            $display("[accel_tilt_angle_speed_class_core] ERROR");
        $finish;
    end

    // Watchdog: far above the slowest legal run.
    initial
    begin
        #2000000;
        $display("[accel_tilt_angle_speed_class_core] ERROR");
        $finish;
    end

endmodule
